// ----- design/fcce_pkg.sv -----
// Shared types and constants for the FAT cluster chain engine.
// No dependencies; imported by fat_cluster_chain_engine and the testbench.
package fcce_pkg;

    // request kinds
    localparam logic [2:0] REQ_READ  = 3'd0;
    localparam logic [2:0] REQ_WRITE = 3'd1;
    localparam logic [2:0] REQ_ALLOC = 3'd2;
    localparam logic [2:0] REQ_FREE  = 3'd3;
    localparam logic [2:0] REQ_SIZE  = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;
    localparam logic [1:0] ST_NOEND   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_CLUSTERS = 2'd0;
    localparam logic [1:0] CFG_WIDE     = 2'd1;
    localparam logic [1:0] CFG_SHIFT    = 2'd2;

    localparam logic [27:0] CLUSTER_MASK = 28'hFFFFFFF;
    localparam logic [31:0] EOC_MARK     = 32'h0FFFFFFF;
    localparam logic [31:0] EOC_WIDE     = 32'h0FFFFFF8;
    localparam logic [31:0] EOC_NARROW   = 32'h0000FFF8;
    localparam logic [31:0] BLOCK_BYTES  = 32'd512;

    typedef enum logic [9:0] {
        S_CLEAR       = 10'b00_0000_0001,
        S_IDLE        = 10'b00_0000_0010,
        S_START       = 10'b00_0000_0100,
        S_RD_WAIT     = 10'b00_0000_1000,
        S_PROBE_ISSUE = 10'b00_0001_0000,
        S_PROBE_EVAL  = 10'b00_0010_0000,
        S_MARK        = 10'b00_0100_0000,
        S_LINK        = 10'b00_1000_0000,
        S_WALK_ISSUE  = 10'b01_0000_0000,
        S_WALK_EVAL   = 10'b10_0000_0000
    } state_t;

endpackage

// ----- design/fcce_table.sv -----
// Cluster table storage: one write port, one read port, registered read data.
// Depends on nothing beyond its parameters.
module fcce_table #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);
    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    // synchronous write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- design/fat_cluster_chain_engine.sv -----
// FAT cluster chain engine, top level: request sequencer around the table.
// Depends on fcce_pkg and fcce_table.
//
// After reset the block sweeps the table to zero, one entry a cycle, and
// accepts no request until the sweep ends (config writes are taken
// throughout). Each request is then handled by a sequencer around one
// single-read-port table with registered read data: a write is done at
// start, a read waits for the entry, a free or size walk issues and
// evaluates each visited cluster, and an allocate probes entries, marks
// the run's end and links it back to front. A finished result sits in an
// output register; the next request is taken while it awaits collection.
module fat_cluster_chain_engine #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // cluster_no[27:0], entry_value[59:28], run_length[72:60]
    input  logic [2:0]  s_tuser,   // req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[1:0], result_value[33:2]
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    import fcce_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [27:0] MAX_C = 28'(TABLE_DEPTH - 2);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

    // configuration registers
    logic [11:0] clusters_reg;
    logic        wide_reg;
    logic [2:0]  shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clusters_reg <= '0;
            wide_reg     <= 1'b1;
            shift_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLUSTERS: clusters_reg <= cfg_data;
                CFG_WIDE:     wide_reg     <= cfg_data[0];
                CFG_SHIFT:    shift_reg    <= cfg_data[2:0];
                default:      ;
            endcase
        end
    end

    // effective count and last valid cluster
    logic [27:0] cnt;
    logic [27:0] last_cl;
    assign cnt     = ({16'd0, clusters_reg} > MAX_C) ? MAX_C : {16'd0, clusters_reg};
    assign last_cl = cnt + 28'd1;

    // sequencer state
    state_t      state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [2:0]  req_reg, req_next;
    logic [27:0] cl_reg, cl_next;
    logic [31:0] val_reg, val_next;
    logic [12:0] len_reg, len_next;
    logic [27:0] bgn_reg, bgn_next;
    logic [27:0] end_reg, end_next;
    logic [12:0] n_reg, n_next;
    logic [31:0] sz_reg, sz_next;
    logic        remember_reg, remember_next;
    logic [27:0] search_reg, search_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_st_reg, out_st_next;
    logic [31:0] out_res_reg, out_res_next;

    // table port
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;

    fcce_table #(
        .DEPTH(TABLE_DEPTH),
        .AW   (AW)
    ) u_table (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // entry view under the current mode
    logic [31:0] rd_masked;
    logic        rd_eoc;
    assign rd_masked = wide_reg ? {4'd0, mem_rdata[27:0]} : {16'd0, mem_rdata[15:0]};
    assign rd_eoc    = rd_masked >= (wide_reg ? EOC_WIDE : EOC_NARROW);

    function automatic logic [31:0] store_val(input logic wide, input logic [31:0] v);
        return wide ? v : {16'd0, v[15:0]};
    endfunction

    logic [31:0] blk_inc;
    logic [12:0] n_inc;
    logic [27:0] run_len;
    assign blk_inc = BLOCK_BYTES << shift_reg;
    assign n_inc   = n_reg + 13'd1;
    assign run_len = end_reg - bgn_reg + 28'd1;

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg, out_st_reg};

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        req_next       = req_reg;
        cl_next        = cl_reg;
        val_next       = val_reg;
        len_next       = len_reg;
        bgn_next       = bgn_reg;
        end_next       = end_reg;
        n_next         = n_reg;
        sz_next        = sz_reg;
        remember_next  = remember_reg;
        search_next    = search_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_st_next    = out_st_reg;
        out_res_next   = out_res_reg;
        mem_we         = 1'b0;
        mem_waddr      = end_reg[AW-1:0];
        mem_wdata      = '0;
        mem_raddr      = end_reg[AW-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next   = s_tuser;
                    cl_next    = s_tdata[27:0];
                    val_next   = s_tdata[59:28];
                    len_next   = s_tdata[72:60];
                    state_next = S_START;
                end
            end
            S_START:
            begin
                // results of one-step requests wait for the output register
                case (req_reg)
                    REQ_READ:
                    begin
                        if (cl_reg > last_cl)
                        begin
                            if (out_free)
                            begin
                                out_valid_next = 1'b1;
                                out_st_next    = ST_RANGE;
                                out_res_next   = '0;
                                state_next     = S_IDLE;
                            end
                        end
                        else
                        begin
                            mem_raddr  = cl_reg[AW-1:0];
                            state_next = S_RD_WAIT;
                        end
                    end
                    REQ_WRITE:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_res_next   = '0;
                            state_next     = S_IDLE;
                            if (cl_reg < 28'd2 || cl_reg > last_cl)
                            begin
                                out_st_next = ST_RANGE;
                            end
                            else
                            begin
                                out_st_next = ST_OK;
                                mem_we      = 1'b1;
                                mem_waddr   = cl_reg[AW-1:0];
                                mem_wdata   = store_val(wide_reg, val_reg);
                            end
                        end
                    end
                    REQ_ALLOC:
                    begin
                        if (cl_reg != 28'd0 && (cl_reg < 28'd2 || cl_reg > last_cl))
                        begin
                            if (out_free)
                            begin
                                out_valid_next = 1'b1;
                                out_st_next    = ST_RANGE;
                                out_res_next   = '0;
                                state_next     = S_IDLE;
                            end
                        end
                        else
                        begin
                            bgn_next      = (cl_reg != 28'd0) ? cl_reg + 28'd1 : search_reg;
                            end_next      = (cl_reg != 28'd0) ? cl_reg + 28'd1 : search_reg;
                            remember_next = (cl_reg == 28'd0) && (len_reg == 13'd1);
                            n_next        = '0;
                            state_next    = S_PROBE_ISSUE;
                        end
                    end
                    REQ_FREE:
                    begin
                        search_next = 28'd2;
                        end_next    = cl_reg;
                        n_next      = '0;
                        state_next  = S_WALK_ISSUE;
                    end
                    REQ_SIZE:
                    begin
                        end_next   = cl_reg;
                        n_next     = '0;
                        sz_next    = '0;
                        state_next = S_WALK_ISSUE;
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_st_next    = ST_OK;
                            out_res_next   = '0;
                            state_next     = S_IDLE;
                        end
                    end
                endcase
            end
            S_RD_WAIT:
            begin
                // keep the entry on the read port while the result waits
                mem_raddr = cl_reg[AW-1:0];
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = ST_OK;
                    out_res_next   = rd_masked;
                    state_next     = S_IDLE;
                end
            end
            S_PROBE_ISSUE:
            begin
                // probe limit, then wrap past the last cluster
                if ({15'd0, n_reg} >= cnt)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_st_next    = ST_NOSPACE;
                        out_res_next   = '0;
                        state_next     = S_IDLE;
                    end
                end
                else if (end_reg > last_cl)
                begin
                    mem_raddr  = AW'(2);
                    bgn_next   = 28'd2;
                    end_next   = 28'd2;
                    state_next = S_PROBE_EVAL;
                end
                else
                begin
                    state_next = S_PROBE_EVAL;
                end
            end
            S_PROBE_EVAL:
            begin
                n_next = n_inc;
                if (rd_masked != 32'd0)
                begin
                    bgn_next   = end_reg + 28'd1;
                    end_next   = end_reg + 28'd1;
                    state_next = S_PROBE_ISSUE;
                end
                else if (run_len == {15'd0, len_reg})
                begin
                    state_next = S_MARK;
                end
                else
                begin
                    end_next   = end_reg + 28'd1;
                    state_next = S_PROBE_ISSUE;
                end
            end
            S_MARK:
            begin
                mem_we     = 1'b1;
                mem_wdata  = store_val(wide_reg, EOC_MARK);
                state_next = S_LINK;
            end
            S_LINK:
            begin
                // link the run back to front, then the tail
                if (end_reg > bgn_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = end_reg[AW-1:0] - AW'(1);
                    mem_wdata = store_val(wide_reg, {4'd0, end_reg});
                    end_next  = end_reg - 28'd1;
                end
                else if (out_free)
                begin
                    if (cl_reg != 28'd0)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = cl_reg[AW-1:0];
                        mem_wdata = store_val(wide_reg, {4'd0, bgn_reg});
                    end
                    if (remember_reg)
                    begin
                        search_next = (bgn_reg + 28'd1) & CLUSTER_MASK;
                    end
                    out_valid_next = 1'b1;
                    out_st_next    = ST_OK;
                    out_res_next   = {4'd0, bgn_reg};
                    state_next     = S_IDLE;
                end
            end
            S_WALK_ISSUE:
            begin
                if (end_reg > last_cl)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_st_next    = ST_RANGE;
                        out_res_next   = '0;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_WALK_EVAL;
                end
            end
            S_WALK_EVAL:
            begin
                // hold here until the result can be delivered
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_res_next   = '0;
                    if (req_reg == REQ_FREE && end_reg < 28'd2)
                    begin
                        out_st_next = ST_RANGE;
                    end
                    else
                    begin
                        if (req_reg == REQ_FREE)
                        begin
                            mem_we = 1'b1;
                        end
                        if (rd_eoc)
                        begin
                            out_st_next = ST_OK;
                            if (req_reg == REQ_SIZE)
                            begin
                                out_res_next = sz_reg + blk_inc;
                            end
                        end
                        else if ({15'd0, n_inc} >= cnt)
                        begin
                            out_st_next = ST_NOEND;
                        end
                        else
                        begin
                            out_valid_next = out_valid_reg && !m_tready;
                            n_next         = n_inc;
                            sz_next        = sz_reg + blk_inc;
                            end_next       = rd_masked[27:0];
                            state_next     = S_WALK_ISSUE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            search_reg    <= 28'd2;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            search_reg    <= search_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        cl_reg       <= cl_next;
        val_reg      <= val_next;
        len_reg      <= len_next;
        bgn_reg      <= bgn_next;
        end_reg      <= end_next;
        n_reg        <= n_next;
        sz_reg       <= sz_next;
        remember_reg <= remember_next;
        out_st_reg   <= out_st_next;
        out_res_reg  <= out_res_next;
    end
endmodule

// ----- dv/tb_fat_cluster_chain_engine.sv -----
// Testbench for fat_cluster_chain_engine: random and directed FAT requests
// checked against a cycle-free model of the cluster table. Needs fcce_pkg.
module tb_fat_cluster_chain_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import fcce_pkg::*;

    // request codes with no function
    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [27:0] clus;
        logic [31:0] val;
        logic [12:0] len;
    } fat_req_t;

    typedef struct packed {
        logic [1:0]  st;
        logic [31:0] val;
    } fat_rsp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [11:0] cfg_data = '0;

    // model state: cluster table, next search start and register copies
    logic [31:0] fat_mirror [4096];
    int unsigned hunt_start;
    int unsigned clusters_cfg;
    bit          wide_cfg;
    int unsigned shift_cfg;

    fat_req_t    pending_reqs [$];
    fat_rsp_t    awaited_rsps [$];
    fat_req_t    in_flight;
    int unsigned n_queued = 0;
    int unsigned n_taken = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 0;
    logic        hold_go = 1'b0;
    bit          calm = 0;
    int unsigned mismatches = 0;

    fat_cluster_chain_engine u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------- table model ----------------
    function automatic int unsigned peek(input int unsigned c);
        return wide_cfg ? (fat_mirror[c[11:0]] & 32'h0FFFFFFF)
                        : (fat_mirror[c[11:0]] & 32'h0000FFFF);
    endfunction

    function automatic bit poke(input int unsigned c, input int unsigned v, input int unsigned last);
        if (c < 2 || c > last)
            return 0;
        fat_mirror[c[11:0]] = wide_cfg ? v : (v & 32'h0000FFFF);
        return 1;
    endfunction

    function automatic bit is_end(input int unsigned v);
        return v >= (wide_cfg ? EOC_WIDE : EOC_NARROW);
    endfunction

    function automatic fat_rsp_t serve_request(input fat_req_t r);
        fat_rsp_t    o;
        int unsigned cnt, last, bgn, fin, n, c, nxt;
        bit          remember, done;
        cnt = (clusters_cfg > 4094) ? 4094 : clusters_cfg;
        last = cnt + 1;
        o.st = ST_OK;
        o.val = '0;
        c = r.clus;
        n = 0;
        done = 0;
        case (r.kind)
            REQ_READ:
                if (c <= last) o.val = peek(c);
                else o.st = ST_RANGE;
            REQ_WRITE:
                if (!poke(c, r.val, last)) o.st = ST_RANGE;
            REQ_ALLOC:
            begin
                if (c != 0 && (c < 2 || c > last))
                    o.st = ST_RANGE;
                else
                begin
                    if (c != 0)
                    begin
                        bgn = c + 1;
                        remember = 0;
                    end
                    else
                    begin
                        bgn = hunt_start;
                        remember = (r.len == 1);
                    end
                    fin = bgn;
                    // wrapping probe for a free run
                    while (!done && o.st == ST_OK)
                    begin
                        if (n >= cnt)
                            o.st = ST_NOSPACE;
                        else
                        begin
                            if (fin > last)
                            begin
                                bgn = 2;
                                fin = 2;
                            end
                            if (peek(fin) != 0)
                                bgn = fin + 1;
                            else if (fin - bgn + 1 == r.len)
                                done = 1;
                            if (!done)
                            begin
                                n++;
                                fin++;
                            end
                        end
                    end
                    if (done)
                    begin
                        void'(poke(fin, EOC_MARK, last));
                        while (fin > bgn)
                        begin
                            void'(poke(fin - 1, fin, last));
                            fin--;
                        end
                        if (c != 0)
                            void'(poke(c, bgn, last));
                        if (remember)
                            hunt_start = (bgn + 1) & 32'h0FFFFFFF;
                        o.val = bgn;
                    end
                end
            end
            REQ_FREE:
            begin
                hunt_start = 2;
                while (!done)
                begin
                    if (c > last)
                    begin
                        o.st = ST_RANGE;
                        done = 1;
                    end
                    else
                    begin
                        nxt = peek(c);
                        if (!poke(c, 0, last))
                        begin
                            o.st = ST_RANGE;
                            done = 1;
                        end
                        else
                        begin
                            c = nxt;
                            n++;
                            if (is_end(c))
                                done = 1;
                            else if (n >= cnt)
                            begin
                                o.st = ST_NOEND;
                                done = 1;
                            end
                        end
                    end
                end
            end
            REQ_SIZE:
            begin
                while (!done)
                begin
                    if (c > last)
                    begin
                        o.st = ST_RANGE;
                        done = 1;
                    end
                    else
                    begin
                        c = peek(c);
                        o.val = o.val + (32'd512 << shift_cfg);
                        n++;
                        if (is_end(c))
                            done = 1;
                        else if (n >= cnt)
                        begin
                            o.st = ST_NOEND;
                            done = 1;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (o.st != ST_OK)
            o.val = '0;
        return o;
    endfunction

    // ---------------- request driver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                awaited_rsps.push_back(serve_request(in_flight));
                n_taken++;
                if (!calm && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 17);
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    in_flight = pending_reqs.pop_front();
                    s_tdata <= {7'd0, in_flight.len, in_flight.val, in_flight.clus};
                    s_tuser <= in_flight.kind;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- result receiver: random stalls and one long hold ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_go && !hold_done)
        begin
            hold_done = 1;
            hold_left = 400;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 16);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // ---------------- result checker ----------------
    always @(posedge clk)
    begin
        fat_rsp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d value %h",
                             m_tdata[1:0], m_tdata[33:2]);
            end
            else
            begin
                want = awaited_rsps.pop_front();
                if (m_tdata[1:0] !== want.st || m_tdata[33:2] !== want.val)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected status %0d value %h, got %0d %h",
                                 want.st, want.val, m_tdata[1:0], m_tdata[33:2]);
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic queue_req(input logic [2:0] kind, input int unsigned clus,
                             input int unsigned val, input int unsigned len);
        fat_req_t r;
        r.kind = kind;
        r.clus = clus[27:0];
        r.val = val;
        r.len = len[12:0];
        pending_reqs.push_back(r);
        n_queued++;
    endtask

    task automatic set_reg(input logic [1:0] idx, input int unsigned v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[11:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CLUSTERS: clusters_cfg = v & 12'hFFF;
            CFG_WIDE:     wide_cfg = v[0];
            CFG_SHIFT:    shift_cfg = v & 7;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (n_taken != n_queued || awaited_rsps.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // cluster numbers mostly near the valid range, sometimes anywhere
    function automatic int unsigned pick_cluster(input int unsigned last);
        case ($urandom_range(0, 9))
            0:       return $urandom() & 32'h0FFFFFFF;
            1:       return $urandom_range(0, 1);
            2:       return last + $urandom_range(0, 2);
            default: return $urandom_range(2, (last < 2) ? 2 : last);
        endcase
    endfunction

    task automatic random_reqs(input int unsigned count);
        int unsigned last, w, pick, v;
        last = ((clusters_cfg > 4094) ? 4094 : clusters_cfg) + 1;
        for (int i = 0; i < count; i++)
        begin
            w = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0:       v = $urandom();
                1:       v = EOC_MARK - $urandom_range(0, 9);
                2:       v = 32'h0000FFF8 + $urandom_range(0, 7);
                default: v = pick_cluster(last);
            endcase
            if (w < 30)
            begin
                pick = ($urandom_range(0, 1) == 0) ? 0 : pick_cluster(last);
                case ($urandom_range(0, 9))
                    0:       queue_req(REQ_ALLOC, pick, $urandom(), $urandom() & 13'h1FFF);
                    1:       queue_req(REQ_ALLOC, pick, $urandom(), $urandom_range(0, last));
                    default: queue_req(REQ_ALLOC, pick, $urandom(), $urandom_range(1, 4));
                endcase
            end
            else if (w < 50)
                queue_req(REQ_SIZE, pick_cluster(last), $urandom(), $urandom() & 13'h1FFF);
            else if (w < 65)
                queue_req(REQ_FREE, pick_cluster(last), $urandom(), $urandom() & 13'h1FFF);
            else if (w < 80)
                queue_req(REQ_READ, pick_cluster(last), $urandom(), $urandom() & 13'h1FFF);
            else if (w < 95)
                queue_req(REQ_WRITE, pick_cluster(last), v, $urandom() & 13'h1FFF);
            else
                queue_req(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)),
                          $urandom(), $urandom(), $urandom());
        end
    endtask

    task automatic run_phase(input int unsigned clus, input int unsigned wide,
                             input int unsigned shift, input int unsigned count);
        set_reg(CFG_CLUSTERS, clus);
        set_reg(CFG_WIDE, wide);
        set_reg(CFG_SHIFT, shift);
        random_reqs(count);
        drain();
    endtask

    initial
    begin
        for (int i = 0; i < 4096; i++)
            fat_mirror[i] = '0;
        hunt_start = 2;
        clusters_cfg = 0;
        wide_cfg = 1;
        shift_cfg = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset registers, then a small wide table
        queue_req(REQ_READ, 1, 0, 0);
        queue_req(REQ_WRITE, 1, 32'hFFFFFFFF, 0);
        queue_req(REQ_ALLOC, 0, 0, 1);
        drain();
        set_reg(CFG_CLUSTERS, 12);
        queue_req(REQ_WRITE, 2, 32'hFFFFFFFF, 0);
        queue_req(REQ_READ, 2, 0, 0);
        queue_req(REQ_WRITE, 13, 32'h0FFFFFF8, 0);
        queue_req(REQ_READ, 14, 0, 0);
        queue_req(REQ_READ, 32'h0FFFFFFF, 0, 0);
        queue_req(REQ_ALLOC, 0, 0, 0);
        queue_req(REQ_ALLOC, 0, 0, 1);
        queue_req(REQ_ALLOC, 0, 0, 3);
        queue_req(REQ_ALLOC, 4, 0, 2);
        queue_req(REQ_ALLOC, 1, 0, 1);
        queue_req(REQ_ALLOC, 14, 0, 1);
        queue_req(REQ_ALLOC, 0, 0, 13'h1FFF);
        queue_req(REQ_SIZE, 4, 0, 0);
        queue_req(REQ_FREE, 4, 0, 0);
        queue_req(REQ_WRITE, 9, 9, 0);
        queue_req(REQ_SIZE, 9, 0, 0);
        queue_req(REQ_FREE, 9, 0, 0);
        queue_req(REQ_FREE, 0, 0, 0);
        queue_req(REQ_SIZE, 14, 0, 0);
        queue_req(REQ_SPARE_LO, 3, 32'hFFFFFFFF, 13'h1FFF);
        queue_req(REQ_SPARE_HI, 0, 0, 0);
        drain();
        // narrow entries, largest cluster size
        set_reg(CFG_WIDE, 0);
        set_reg(CFG_SHIFT, 7);
        queue_req(REQ_WRITE, 3, 32'hABCDFFFF, 0);
        queue_req(REQ_READ, 3, 0, 0);
        queue_req(REQ_SIZE, 3, 0, 0);
        drain();

        // random phases; the receiver holds off once in the first
        @(posedge clk);
        hold_go <= 1'b1;
        run_phase(20, 1, 0, 250);
        run_phase(6, 0, 7, 250);
        run_phase(4095, 1, 3, 20);
        run_phase(0, 0, 1, 40);
        run_phase($urandom_range(3, 40), $urandom_range(0, 1), $urandom_range(0, 7), 300);
        run_phase($urandom_range(3, 40), $urandom_range(0, 1), $urandom_range(0, 7), 300);
        run_phase(2, 1, 5, 150);
        run_phase($urandom_range(40, 120), 1, 2, 250);
        calm = 1;
        run_phase($urandom_range(3, 30), $urandom_range(0, 1), $urandom_range(0, 7), 350);
        repeat (20) @(posedge clk);

        if (mismatches == 0 && awaited_rsps.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
